/* design/pzg_pkg.sv */
// shared types and constants of the pinch zoom gesture detector
`default_nettype none
package pzg_pkg;

  localparam int COORD_BITS_DEF     = 12;
  localparam int SPAN_FRAC_BITS_DEF = 4;
  localparam int ACTION_W           = 2;
  localparam int COUNT_W            = 4;
  localparam int GESTURE_W          = 2;
  localparam int SPAN_W             = 17;
  localparam int CENTER_W           = 13;
  localparam int HIST_W             = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DOWN  = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_UP    = 2'd2,
    ACT_OTHER = 2'd3
  } action_e;

  typedef enum logic [GESTURE_W-1:0] {
    G_UNKNOWN = 2'd0,
    G_BEGIN   = 2'd1,
    G_ZOOM    = 2'd2,
    G_END     = 2'd3
  } gesture_e;

  localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] CNT_TWO = COUNT_W'(2);
  localparam logic [HIST_W-1:0]  HIST_FULL = HIST_W'(3);
  localparam logic [HIST_W-1:0]  HIST_ONE  = HIST_W'(1);

endpackage
`default_nettype wire

/* design/pzg_if.sv */
// handshake interfaces for touch event and gesture result words
`default_nettype none
interface pzg_evt_if
  import pzg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [COUNT_W-1:0]    point_count;
  logic [COORD_BITS-1:0] x_first;
  logic [COORD_BITS-1:0] y_first;
  logic [COORD_BITS-1:0] x_second;
  logic [COORD_BITS-1:0] y_second;

  modport source (output valid, action, point_count, x_first, y_first, x_second, y_second,
                  input ready);
  modport sink (input valid, action, point_count, x_first, y_first, x_second, y_second,
                output ready);
endinterface

interface pzg_res_if
  import pzg_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [GESTURE_W-1:0] gesture;
  logic [SPAN_W-1:0]    span;
  logic [CENTER_W-1:0]  center_x_half;
  logic [CENTER_W-1:0]  center_y_half;

  modport source (output valid, gesture, span, center_x_half, center_y_half, input ready);
  modport sink (input valid, gesture, span, center_x_half, center_y_half, output ready);
endinterface
`default_nettype wire

/* design/pinch_zoom_gesture_detector_unit.sv */
// pinch zoom gesture detector: one touch event word in, one gesture word out
//
// evt_i takes a touch event word (action, point count, first two points) when
// valid and ready are both high; res_o delivers one gesture word per event.
// ready on evt_i is high only while the sequencer is idle, so one event is in
// work at a time. a two point event squares dx and dy on one shared multiplier,
// adds them, then runs a restoring square root one result bit per cycle, and
// forms the result in a final step. events with fewer than two points skip
// the arithmetic and go straight to the final step.
// the result sits in an output register; the next event is accepted while it
// waits. if the receiver stalls longer, a finished event holds in its last
// step until the output register is free.
// reset clears the history, the stored previous event and the output valid.
`default_nettype none
module pinch_zoom_gesture_detector_unit
  import pzg_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SPAN_FRAC_BITS = SPAN_FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pzg_evt_if.sink    evt_i,
  pzg_res_if.source  res_o
);

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int ITER   = (SUM_W + 2 * SPAN_FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ITER;
  localparam int REM_W  = ITER + 2;
  localparam int CNT_W  = $clog2(ITER);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_FIN
  } state_e;

  state_e                state_q, state_d;
  logic [ACTION_W-1:0]   act_q, act_d;
  logic [COUNT_W-1:0]    cnt_pts_q, cnt_pts_d;
  logic [COORD_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [CENTER_W-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [PROD_W-1:0]     sqx_q, sqx_d, sqy_q, sqy_d;
  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ITER-1:0]       root_q, root_d;
  logic [CNT_W-1:0]      it_q, it_d;

  logic [HIST_W-1:0]     hist_q, hist_d;
  logic [COUNT_W-1:0]    prev_cnt_q, prev_cnt_d;
  logic [ACTION_W-1:0]   prev_act_q, prev_act_d;
  logic [SPAN_W-1:0]     prev_span_q, prev_span_d;
  logic [CENTER_W-1:0]   prev_cx_q, prev_cx_d, prev_cy_q, prev_cy_d;

  logic                  out_vld_q, out_vld_d;
  logic [GESTURE_W-1:0]  out_g_q, out_g_d;
  logic [SPAN_W-1:0]     out_span_q, out_span_d;
  logic [CENTER_W-1:0]   out_cx_q, out_cx_d, out_cy_q, out_cy_d;

  logic [COORD_BITS-1:0] mul_a;
  logic [PROD_W-1:0]     mul_p;
  logic [SUM_W-1:0]      sum_w;
  logic [REM_W-1:0]      rem_sh, trial;
  logic                  two_plus;
  logic [SPAN_W-1:0]     span_w;
  logic [CENTER_W-1:0]   cx_w, cy_w;

  // shared squaring unit
  assign mul_a = (state_q == ST_SQX) ? dx_q : dy_q;
  assign mul_p = mul_a * mul_a;
  assign sum_w = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  assign two_plus = (cnt_pts_q >= CNT_TWO);
  assign span_w   = two_plus ? SPAN_W'(root_q) : '0;
  assign cx_w     = two_plus ? cx_q : '0;
  assign cy_w     = two_plus ? cy_q : '0;

  assign evt_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = out_vld_q;
  assign res_o.gesture       = out_g_q;
  assign res_o.span          = out_span_q;
  assign res_o.center_x_half = out_cx_q;
  assign res_o.center_y_half = out_cy_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cnt_pts_d   = cnt_pts_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    it_d        = it_q;
    hist_d      = hist_q;
    prev_cnt_d  = prev_cnt_q;
    prev_act_d  = prev_act_q;
    prev_span_d = prev_span_q;
    prev_cx_d   = prev_cx_q;
    prev_cy_d   = prev_cy_q;
    out_vld_d   = out_vld_q && !res_o.ready;
    out_g_d     = out_g_q;
    out_span_d  = out_span_q;
    out_cx_d    = out_cx_q;
    out_cy_d    = out_cy_q;
    case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          act_d     = evt_i.action;
          cnt_pts_d = evt_i.point_count;
          dx_d = (evt_i.x_first > evt_i.x_second) ? evt_i.x_first - evt_i.x_second
                                                  : evt_i.x_second - evt_i.x_first;
          dy_d = (evt_i.y_first > evt_i.y_second) ? evt_i.y_first - evt_i.y_second
                                                  : evt_i.y_second - evt_i.y_first;
          cx_d = CENTER_W'({1'b0, evt_i.x_first} + {1'b0, evt_i.x_second});
          cy_d = CENTER_W'({1'b0, evt_i.y_first} + {1'b0, evt_i.y_second});
          state_d = (evt_i.point_count >= CNT_TWO) ? ST_SQX : ST_FIN;
        end
      end
      ST_SQX: begin
        sqx_d   = mul_p;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        sqy_d   = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        rad_d   = RAD_W'(sum_w) << (2 * SPAN_FRAC_BITS);
        rem_d   = '0;
        root_d  = '0;
        it_d    = CNT_W'(ITER - 1);
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ITER-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ITER-2:0], 1'b0};
        end
        it_d = it_q - CNT_W'(1);
        if (it_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || res_o.ready) begin
          if (act_q == ACT_DOWN && cnt_pts_q == CNT_ONE) begin
            hist_d = HIST_ONE;
          end else if (hist_q < HIST_FULL) begin
            hist_d = hist_q + HIST_W'(1);
          end
          out_vld_d  = 1'b1;
          out_g_d    = G_UNKNOWN;
          out_span_d = '0;
          out_cx_d   = '0;
          out_cy_d   = '0;
          if (cnt_pts_q == CNT_TWO) begin
            out_span_d = span_w;
            out_cx_d   = cx_w;
            out_cy_d   = cy_w;
            case (act_q)
              ACT_DOWN: out_g_d = G_BEGIN;
              ACT_MOVE: out_g_d = G_ZOOM;
              ACT_UP:   out_g_d = G_END;
              default:  out_g_d = G_UNKNOWN;
            endcase
          end else if (cnt_pts_q == CNT_ONE && hist_d == HIST_FULL &&
                       prev_cnt_q == CNT_TWO && prev_act_q != ACT_UP) begin
            out_g_d    = G_END;
            out_span_d = prev_span_q;
            out_cx_d   = prev_cx_q;
            out_cy_d   = prev_cy_q;
          end
          prev_cnt_d  = cnt_pts_q;
          prev_act_d  = act_q;
          prev_span_d = span_w;
          prev_cx_d   = cx_w;
          prev_cy_d   = cy_w;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist_q      <= '0;
      prev_cnt_q  <= '0;
      prev_act_q  <= '0;
      prev_span_q <= '0;
      prev_cx_q   <= '0;
      prev_cy_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist_q      <= hist_d;
      prev_cnt_q  <= prev_cnt_d;
      prev_act_q  <= prev_act_d;
      prev_span_q <= prev_span_d;
      prev_cx_q   <= prev_cx_d;
      prev_cy_q   <= prev_cy_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    cnt_pts_q  <= cnt_pts_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    sqx_q      <= sqx_d;
    sqy_q      <= sqy_d;
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    it_q       <= it_d;
    out_g_q    <= out_g_d;
    out_span_q <= out_span_d;
    out_cx_q   <= out_cx_d;
    out_cy_q   <= out_cy_d;
  end

  // one event in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.valid && evt_i.ready |=> !evt_i.ready)
    else $error("event accepted while previous one in work");

  // a new result word only comes out of the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == ST_FIN))
    else $error("result word without a finished event");

  // any delivered word implies a nonempty history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> hist_q != '0)
    else $error("result word with empty history");

  // square root loop always ends in the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT && it_q == '0 |=> state_q == ST_FIN)
    else $error("square root loop did not finish");

endmodule
`default_nettype wire
